// File: design/rc4_stream_cipher_core_macros.svh
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core_macros.svh
// Assertion macros used by the RC4 core checker.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_CORE_MACROS_SVH
`define RC4_STREAM_CIPHER_CORE_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define RC4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication
`define RC4_ASSERT_IMPL(label, ante, cons, msg) \
  `RC4_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
  `RC4_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: design/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types, constants and helpers of the RC4 stream cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  // Permutation store geometry
  localparam int unsigned PermDepth = 256;
  localparam int unsigned PermAw    = 8;
  localparam int unsigned ByteW     = 8;

  // Key register file
  localparam int unsigned KeyRegW   = 64;
  localparam int unsigned KeyW      = 128;
  localparam int unsigned KeyLenW   = 5;
  localparam int unsigned KeyIdxW   = 4;
  localparam int unsigned CfgIdxW   = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKeyLen  = 2'd2;

  // Key material as seen by the sequencer
  typedef struct packed {
    logic [KeyW-1:0]    key;  // byte 0 in bits 7:0
    logic [KeyLenW-1:0] len;  // clamped key length
  } key_cfg_t;

  // Select one key byte
  function automatic logic [ByteW-1:0] key_byte(input logic [KeyW-1:0] key,
                                                input logic [KeyIdxW-1:0] idx);
    key_byte = key[{idx, 3'b000} +: ByteW];
  endfunction

endpackage

// File: design/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-clock RAM, one write port and one registered read port.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rc4_cfg_regs.sv
// ----------------------------------------------------------------------------
// rc4_cfg_regs
// Key registers with write port; presents key bytes and clamped length.
// ----------------------------------------------------------------------------
module rc4_cfg_regs #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rc4_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rc4_pkg::KeyRegW-1:0]      cfg_wdata_i,
  output rc4_pkg::key_cfg_t                key_cfg_o
);

  localparam logic [rc4_pkg::KeyLenW-1:0] MaxLen = rc4_pkg::KeyLenW'(MAX_KEY_BYTES);

  logic [rc4_pkg::KeyRegW-1:0] key_low_q,  key_low_d;
  logic [rc4_pkg::KeyRegW-1:0] key_high_q, key_high_d;
  logic [rc4_pkg::KeyLenW-1:0] key_len_q,  key_len_d;

  // Register decode; unknown indexes are dropped
  always_comb begin
    key_low_d  = key_low_q;
    key_high_d = key_high_q;
    key_len_d  = key_len_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        rc4_pkg::RegKeyLow:  key_low_d  = cfg_wdata_i;
        rc4_pkg::RegKeyHigh: key_high_d = cfg_wdata_i;
        rc4_pkg::RegKeyLen:  key_len_d  = cfg_wdata_i[rc4_pkg::KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= '0;
    end else begin
      key_low_q  <= key_low_d;
      key_high_q <= key_high_d;
      key_len_q  <= key_len_d;
    end
  end

  // Lengths above the supported maximum are clamped
  assign key_cfg_o.key = {key_high_q, key_low_q};
  assign key_cfg_o.len = (key_len_q > MaxLen) ? MaxLen : key_len_q;

endmodule

// File: design/rc4_stream_cipher_core.sv
// Sequencing: a keyed item is taken in StIdle and walks StG1 to StG4 on the
// single permutation RAM; no new item is taken until its result is registered.
// An item with start_of_message first runs an identity fill of all 256
// entries, then the key schedule (StK1, then StK2 to StK4 per step).
// Key error items go straight to StDone.
// Reset clears indices, keyed flag and handshakes; the RAM is not cleared.
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 byte stream cipher: each keyed input byte is XORed with the next keystream
// byte. The permutation lives in one RAM driven by a small sequencer.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // [7:0] data_in
  input  logic                        s_axis_tuser_i,  // [0] start_of_message
  // Output stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o,  // [7:0] data_out
  output logic                        m_axis_tuser_o,  // [0] key_error
  // Configuration
  input  logic                        cfg_we_i,
  input  logic [rc4_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rc4_pkg::KeyRegW-1:0] cfg_wdata_i
);

  localparam int unsigned Aw = rc4_pkg::PermAw;
  localparam int unsigned Bw = rc4_pkg::ByteW;

  // Sequencer states
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StFill = 4'd1;
  localparam logic [3:0] StK1   = 4'd2;
  localparam logic [3:0] StK2   = 4'd3;
  localparam logic [3:0] StK3   = 4'd4;
  localparam logic [3:0] StK4   = 4'd5;
  localparam logic [3:0] StG1   = 4'd6;
  localparam logic [3:0] StG2   = 4'd7;
  localparam logic [3:0] StG3   = 4'd8;
  localparam logic [3:0] StG4   = 4'd9;
  localparam logic [3:0] StDone = 4'd10;

  rc4_pkg::key_cfg_t key_cfg;

  logic [3:0]                  state_q, state_d;
  logic [Aw-1:0]               i_q, i_d;
  logic [Aw-1:0]               j_q, j_d;
  logic [Aw-1:0]               n_q, n_d;
  logic [rc4_pkg::KeyIdxW-1:0] kidx_q, kidx_d;
  logic                        keyed_q, keyed_d;
  logic                        fwd_q, fwd_d;
  logic                        fi_q, fi_d;
  logic                        fj_q, fj_d;
  logic                        m_valid_q, m_valid_d;
  logic [Bw-1:0]               si_q, si_d;
  logic [Bw-1:0]               sj_q, sj_d;
  logic [Bw-1:0]               ks_q, ks_d;
  logic [Bw-1:0]               data_q, data_d;
  logic                        err_q, err_d;
  logic [Bw-1:0]               m_data_q, m_data_d;
  logic                        m_err_q, m_err_d;

  logic                        ram_we, ram_re;
  logic [Aw-1:0]               ram_waddr, ram_raddr;
  logic [Bw-1:0]               ram_wdata, ram_rdata;

  logic                        s_accept;
  logic                        out_free;
  logic [Bw-1:0]               rd_fwd;
  logic [Bw-1:0]               ks_now;
  logic [Aw-1:0]               sum_t;
  logic [Aw-1:0]               n_inc;
  logic [rc4_pkg::KeyLenW-1:0] len_last;

  rc4_cfg_regs #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_cfg_o   (key_cfg)
  );

  rc4_ram #(
    .Width (Bw),
    .Depth (rc4_pkg::PermDepth)
  ) u_perm (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  // Forwarded read data and keystream byte
  assign rd_fwd   = fwd_q ? si_q : ram_rdata;
  assign ks_now   = fj_q ? si_q : (fi_q ? sj_q : ram_rdata);
  assign sum_t    = si_q + ram_rdata;
  assign n_inc    = n_q + 1'b1;
  assign len_last = key_cfg.len - 1'b1;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    n_d       = n_q;
    kidx_d    = kidx_q;
    keyed_d   = keyed_q;
    fwd_d     = fwd_q;
    fi_d      = fi_q;
    fj_d      = fj_q;
    si_d      = si_q;
    sj_d      = sj_q;
    ks_d      = ks_q;
    data_d    = data_q;
    err_d     = err_q;
    m_data_d  = m_data_q;
    m_err_d   = m_err_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    case (state_q)
      StIdle: begin
        if (s_accept) begin
          data_d = s_axis_tdata_i;
          err_d  = 1'b0;
          if (s_axis_tuser_i) begin
            i_d = '0;
            j_d = '0;
            n_d = '0;
            if (key_cfg.len == '0) begin
              keyed_d = 1'b0;
              err_d   = 1'b1;
              state_d = StDone;
            end else begin
              state_d = StFill;
            end
          end else if (!keyed_q || key_cfg.len == '0) begin
            err_d   = 1'b1;
            state_d = StDone;
          end else begin
            state_d = StG1;
          end
        end
      end

      // Identity fill, one entry per cycle
      StFill: begin
        ram_we    = 1'b1;
        ram_waddr = n_q;
        ram_wdata = n_q;
        n_d       = n_inc;
        if (n_q == '1) begin
          kidx_d  = '0;
          state_d = StK1;
        end
      end

      // Key schedule: fetch S[n] for the first step
      StK1: begin
        ram_re    = 1'b1;
        ram_raddr = n_q;
        fwd_d     = 1'b0;
        state_d   = StK2;
      end

      // S[n] arrives; new j, fetch S[j]
      StK2: begin
        si_d      = rd_fwd;
        j_d       = j_q + rd_fwd + rc4_pkg::key_byte(key_cfg.key, kidx_q);
        ram_re    = 1'b1;
        ram_raddr = j_d;
        state_d   = StK3;
      end

      // S[n] <= S[j]
      StK3: begin
        ram_we    = 1'b1;
        ram_waddr = n_q;
        ram_wdata = ram_rdata;
        state_d   = StK4;
      end

      // S[j] <= old S[n]; prefetch S[n+1] with forwarding
      StK4: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        ram_re    = 1'b1;
        ram_raddr = n_inc;
        fwd_d     = (j_q == n_inc);
        n_d       = n_inc;
        kidx_d    = ({1'b0, kidx_q} == len_last) ? '0 : kidx_q + 1'b1;
        if (n_q == '1) begin
          keyed_d = 1'b1;
          i_d     = '0;
          j_d     = '0;
          state_d = StG1;
        end else begin
          state_d = StK2;
        end
      end

      // Keystream: fetch S[i+1]
      StG1: begin
        i_d       = i_q + 1'b1;
        ram_re    = 1'b1;
        ram_raddr = i_d;
        state_d   = StG2;
      end

      // S[i] arrives; new j, fetch S[j]
      StG2: begin
        si_d      = ram_rdata;
        j_d       = j_q + ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = j_d;
        state_d   = StG3;
      end

      // S[i] <= S[j]; fetch S[si+sj], noting overlap with the swap
      StG3: begin
        sj_d      = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = sum_t;
        fj_d      = (sum_t == j_q);
        fi_d      = (sum_t == i_q);
        state_d   = StG4;
      end

      // S[j] <= old S[i]; keystream byte ready
      StG4: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        ks_d      = ks_now;
        if (out_free) begin
          m_data_d  = data_q ^ ks_now;
          m_err_d   = 1'b0;
          m_valid_d = 1'b1;
          state_d   = StIdle;
        end else begin
          state_d   = StDone;
        end
      end

      // Wait for the output register
      StDone: begin
        if (out_free) begin
          m_data_d  = err_q ? '0 : (data_q ^ ks_q);
          m_err_d   = err_q;
          m_valid_d = 1'b1;
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      i_q       <= '0;
      j_q       <= '0;
      n_q       <= '0;
      kidx_q    <= '0;
      keyed_q   <= 1'b0;
      fwd_q     <= 1'b0;
      fi_q      <= 1'b0;
      fj_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      n_q       <= n_d;
      kidx_q    <= kidx_d;
      keyed_q   <= keyed_d;
      fwd_q     <= fwd_d;
      fi_q      <= fi_d;
      fj_q      <= fj_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    si_q     <= si_d;
    sj_q     <= sj_d;
    ks_q     <= ks_d;
    data_q   <= data_d;
    err_q    <= err_d;
    m_data_q <= m_data_d;
    m_err_q  <= m_err_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_err_q;

endmodule

// File: design/rc4_checker.sv
// ----------------------------------------------------------------------------
// rc4_checker
// Port-level checks of the RC4 core, bound to the top level.
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_core_macros.svh"

module rc4_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o
);

  // Stalled result holds
  `RC4_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "result dropped while stalled")
  `RC4_ASSERT_NEXT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

  // Key error results carry zero data
  `RC4_ASSERT_IMPL(a_err_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == 8'h00, "key error with nonzero data")

  // One item in work at a time
  `RC4_ASSERT_NEXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "item accepted while busy")

  // A new result appears only as the item's work ends
  `RC4_ASSERT_IMPL(a_done_idle, $rose(m_axis_tvalid_o), s_axis_tready_o, "result shown before work ended")

endmodule

bind rc4_stream_cipher_core rc4_checker u_rc4_checker (.*);
